// ----- sv/baud_divisor_search_defines.svh -----
// ----------------------------------------------------------------------------
// Baud divisor search: assertion macros
// Shared concurrent assertion forms. The using scope provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef BAUD_DIVISOR_SEARCH_DEFINES_SVH
`define BAUD_DIVISOR_SEARCH_DEFINES_SVH

// same-cycle implication
`define BDS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bds assertion failed");

// next-cycle implication
`define BDS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bds assertion failed");

`endif

// ----- sv/bds_pkg.sv -----
// ----------------------------------------------------------------------------
// Baud divisor search package
// Widths, constants, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package bds_pkg;

  localparam int BAUD_W     = 19;
  localparam int PRODUCT_W  = 29;
  localparam int DIVIDEND_W = 30;
  localparam int DIVISOR_W  = 19;
  localparam int PRESCALE_W = 16;
  localparam int DIV_INT_W  = 2;
  localparam int FRAC_W     = 11;
  localparam int DMAX_W     = PRODUCT_W - FRAC_W;

  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // x / 8191 as (x * (2^29 + 2^16 + 2^3 + 1)) >> 42, exact for x < 2^29
  localparam int RECIP_W     = 60;
  localparam int RECIP_SHIFT = 42;
  localparam int RECIP_SH0   = 29;
  localparam int RECIP_SH1   = 16;
  localparam int RECIP_SH2   = 3;

  localparam logic [DIVIDEND_W-1:0] CLOCK_PRODUCT = 30'd1024000000;
  localparam logic [BAUD_W-1:0]     BAUD_MIN      = 19'd2;
  localparam logic [BAUD_W-1:0]     BAUD_MAX      = 19'd500000;
  localparam logic [DIVIDEND_W-1:0] CEIL_BIAS     = 30'd8190;
  localparam logic [PRESCALE_W-1:0] PRESCALE_MAX  = 16'd65535;
  localparam logic [PRODUCT_W-1:0]  PRODUCT_MAX   = 29'd536797185;
  localparam logic [PRODUCT_W-1:0]  PRODUCT_MIN   = 29'd2048;
  localparam logic [DIVIDEND_W-1:0] QUOT_MIN      = 30'd2048;
  localparam logic [DIVIDEND_W-1:0] QUOT_MAX      = 30'd8191;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE_DIV,
    ST_BASE_WAIT,
    ST_BOUNDS,
    ST_RANGE,
    ST_RANGE_CHK,
    ST_TRIAL_DIV,
    ST_TRIAL_WAIT,
    ST_TRIAL_CHK,
    ST_ADVANCE,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    SEL_BASE,
    SEL_TRIAL
  } div_sel_t;

  typedef struct packed {
    logic     load_baud;
    logic     div_start;
    div_sel_t div_sel;
    logic     set_bounds;
    logic     set_range;
    logic     next_d;
    logic     advance;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic rem_zero;
    logic d_gt;
    logic d_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/bds_div.sv -----
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle; result held until restart.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [bds_pkg::DIVIDEND_W-1:0]   dividend,
  input  wire logic [bds_pkg::DIVISOR_W-1:0]    divisor,
  output logic                                  busy,
  output logic                                  done,
  output logic [bds_pkg::DIVIDEND_W-1:0]        quot,
  output logic [bds_pkg::DIVISOR_W-1:0]         rem
);

  logic                            busy_r;
  logic                            done_r;
  logic [bds_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [bds_pkg::DIVIDEND_W-1:0]  dvd_r;
  logic [bds_pkg::DIVISOR_W-1:0]   dvs_r;
  logic [bds_pkg::DIVISOR_W-1:0]   rem_r;

  logic [bds_pkg::DIVISOR_W:0]     shifted;
  logic                            qbit;
  logic [bds_pkg::DIVISOR_W-1:0]   rem_nxt;

  always_comb begin
    shifted = {rem_r, dvd_r[bds_pkg::DIVIDEND_W-1]};
    qbit    = (shifted >= {1'b0, dvs_r});
    rem_nxt = qbit ? bds_pkg::DIVISOR_W'(shifted - {1'b0, dvs_r})
                   : shifted[bds_pkg::DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == bds_pkg::DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[bds_pkg::DIVIDEND_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- sv/bds_dp.sv -----
// ----------------------------------------------------------------------------
// Baud divisor search datapath
// Target bounds, candidate product, prescaler range, divider and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "baud_divisor_search_defines.svh"

module bds_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bds_pkg::cmd_t                     cmd,
  output bds_pkg::status_t                       sts,
  input  wire logic [bds_pkg::BAUD_W-1:0]        in_baud,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bds_pkg::PRESCALE_W-1:0]         out_prescale,
  output logic [bds_pkg::DIV_INT_W-1:0]          out_div_int,
  output logic [bds_pkg::FRAC_W-1:0]             out_div_frac,
  output logic [bds_pkg::PRODUCT_W-1:0]          out_achieved_product
);

  logic [bds_pkg::BAUD_W-1:0]      baud_r;
  logic [bds_pkg::PRODUCT_W-1:0]   lo_r;
  logic [bds_pkg::PRODUCT_W-1:0]   hi_r;
  logic [bds_pkg::PRODUCT_W-1:0]   p_r;
  logic [bds_pkg::PRESCALE_W-1:0]  d_r;
  logic [bds_pkg::PRESCALE_W-1:0]  dmax_r;
  logic                            out_valid_r;
  logic [bds_pkg::PRESCALE_W-1:0]  prescale_r;
  logic [bds_pkg::DIV_INT_W-1:0]   div_int_r;
  logic [bds_pkg::FRAC_W-1:0]      div_frac_r;
  logic [bds_pkg::PRODUCT_W-1:0]   product_r;

  logic [bds_pkg::BAUD_W-1:0]      baud_clamped;
  logic [bds_pkg::DIVIDEND_W-1:0]  div_dividend;
  logic [bds_pkg::DIVISOR_W-1:0]   div_divisor;
  logic                            div_busy;
  logic                            div_done;
  logic [bds_pkg::DIVIDEND_W-1:0]  div_quot;
  logic [bds_pkg::DIVISOR_W-1:0]   div_rem;
  logic [bds_pkg::PRODUCT_W-1:0]   q_prod;
  logic                            rem_nz;
  logic                            round_up;
  logic [bds_pkg::DIVIDEND_W-1:0]  ceil_num;
  logic [bds_pkg::RECIP_W-1:0]     ceil_ext;
  logic [bds_pkg::RECIP_W-1:0]     ceil_prod;
  logic [bds_pkg::PRESCALE_W-1:0]  dmin;
  logic [bds_pkg::DMAX_W-1:0]      p_shr;
  logic [bds_pkg::PRESCALE_W-1:0]  dmax;

  always_comb begin
    baud_clamped = in_baud;
    if (in_baud < bds_pkg::BAUD_MIN) baud_clamped = bds_pkg::BAUD_MIN;
    if (in_baud > bds_pkg::BAUD_MAX) baud_clamped = bds_pkg::BAUD_MAX;
  end

  always_comb begin
    unique case (cmd.div_sel)
      bds_pkg::SEL_BASE: begin
        div_dividend = bds_pkg::CLOCK_PRODUCT;
        div_divisor  = baud_r;
      end
      bds_pkg::SEL_TRIAL: begin
        div_dividend = bds_pkg::DIVIDEND_W'(p_r);
        div_divisor  = bds_pkg::DIVISOR_W'(d_r);
      end
      default: begin
        div_dividend = bds_pkg::DIVIDEND_W'(p_r);
        div_divisor  = bds_pkg::DIVISOR_W'(d_r);
      end
    endcase
  end

  bds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    q_prod    = div_quot[bds_pkg::PRODUCT_W-1:0];
    rem_nz    = (div_rem != '0);
    round_up  = ({div_rem, 1'b0} >= {1'b0, baud_r});
    // ceil(p / 8191) by reciprocal multiply
    ceil_num  = bds_pkg::DIVIDEND_W'(p_r) + bds_pkg::CEIL_BIAS;
    ceil_ext  = bds_pkg::RECIP_W'(ceil_num);
    ceil_prod = (ceil_ext << bds_pkg::RECIP_SH0) + (ceil_ext << bds_pkg::RECIP_SH1)
              + (ceil_ext << bds_pkg::RECIP_SH2) + ceil_ext;
    dmin      = ceil_prod[bds_pkg::RECIP_SHIFT +: bds_pkg::PRESCALE_W];
    if (dmin == '0) dmin = bds_pkg::PRESCALE_W'(1);
    p_shr    = p_r[bds_pkg::PRODUCT_W-1:bds_pkg::FRAC_W];
    dmax     = (p_shr > bds_pkg::DMAX_W'(bds_pkg::PRESCALE_MAX)) ? bds_pkg::PRESCALE_MAX
                                                               : p_shr[bds_pkg::PRESCALE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_baud) baud_r <= baud_clamped;
    if (cmd.set_bounds) begin
      lo_r <= q_prod;
      hi_r <= q_prod + bds_pkg::PRODUCT_W'(rem_nz);
      p_r  <= q_prod + bds_pkg::PRODUCT_W'(round_up);
    end else if (cmd.advance) begin
      if (p_r == hi_r) begin
        if (hi_r < bds_pkg::PRODUCT_MAX) hi_r <= hi_r + 1'b1;
        p_r <= lo_r;
      end else begin
        if (lo_r > bds_pkg::PRODUCT_MIN) lo_r <= lo_r - 1'b1;
        p_r <= hi_r;
      end
    end
    if (cmd.set_range) begin
      d_r    <= dmin;
      dmax_r <= dmax;
    end else if (cmd.next_d) begin
      d_r <= d_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      prescale_r <= d_r;
      div_int_r  <= div_quot[bds_pkg::FRAC_W +: bds_pkg::DIV_INT_W];
      div_frac_r <= div_quot[bds_pkg::FRAC_W-1:0];
      product_r  <= p_r;
    end
  end

  always_comb begin
    sts.div_done = div_done;
    sts.rem_zero = !rem_nz;
    sts.d_gt     = (d_r > dmax_r);
    sts.d_last   = (d_r == dmax_r);
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid            = out_valid_r;
  assign out_prescale         = prescale_r;
  assign out_div_int          = div_int_r;
  assign out_div_frac         = div_frac_r;
  assign out_achieved_product = product_r;

  `BDS_ASSERT_IMP(a_done_after_busy, div_done, $past(div_busy))
  `BDS_ASSERT_IMP(a_start_when_free, cmd.div_start, !div_busy)
  `BDS_ASSERT_IMP(a_cand_on_bound, cmd.set_range, (p_r == lo_r) || (p_r == hi_r))
  `BDS_ASSERT_IMP(a_exact_fit, cmd.load_out, !rem_nz && (div_quot >= bds_pkg::QUOT_MIN) && (div_quot <= bds_pkg::QUOT_MAX))
  `BDS_ASSERT_NXT(a_result_shown, cmd.load_out, out_valid_r && (product_r == $past(p_r)))

endmodule

`default_nettype wire

// ----- sv/bds_ctrl.sv -----
// ----------------------------------------------------------------------------
// Baud divisor search controller
// Sequences target division, prescaler range set-up, trials and candidate walk.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output bds_pkg::cmd_t          cmd,
  input  wire bds_pkg::status_t  sts
);

  bds_pkg::state_t state_r;
  bds_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bds_pkg::ST_IDLE:       if (in_valid) state_nxt = bds_pkg::ST_BASE_DIV;
      bds_pkg::ST_BASE_DIV:   state_nxt = bds_pkg::ST_BASE_WAIT;
      bds_pkg::ST_BASE_WAIT:  if (sts.div_done) state_nxt = bds_pkg::ST_BOUNDS;
      bds_pkg::ST_BOUNDS:     state_nxt = bds_pkg::ST_RANGE;
      bds_pkg::ST_RANGE:      state_nxt = bds_pkg::ST_RANGE_CHK;
      bds_pkg::ST_RANGE_CHK: begin
        state_nxt = sts.d_gt ? bds_pkg::ST_ADVANCE : bds_pkg::ST_TRIAL_DIV;
      end
      bds_pkg::ST_TRIAL_DIV:  state_nxt = bds_pkg::ST_TRIAL_WAIT;
      bds_pkg::ST_TRIAL_WAIT: if (sts.div_done) state_nxt = bds_pkg::ST_TRIAL_CHK;
      bds_pkg::ST_TRIAL_CHK: begin
        priority if (sts.rem_zero) state_nxt = bds_pkg::ST_FINISH;
        else if (sts.d_last)       state_nxt = bds_pkg::ST_ADVANCE;
        else                       state_nxt = bds_pkg::ST_TRIAL_DIV;
      end
      bds_pkg::ST_ADVANCE:    state_nxt = bds_pkg::ST_RANGE;
      bds_pkg::ST_FINISH:     if (sts.out_free) state_nxt = bds_pkg::ST_IDLE;
      default:                state_nxt = bds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.div_sel  = bds_pkg::SEL_BASE;
    in_stall     = 1'b1;
    unique case (state_r)
      bds_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_baud = in_valid;
      end
      bds_pkg::ST_BASE_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = bds_pkg::SEL_BASE;
      end
      bds_pkg::ST_BOUNDS:    cmd.set_bounds = 1'b1;
      bds_pkg::ST_RANGE:     cmd.set_range = 1'b1;
      bds_pkg::ST_TRIAL_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = bds_pkg::SEL_TRIAL;
      end
      bds_pkg::ST_TRIAL_CHK: cmd.next_d = !sts.rem_zero && !sts.d_last;
      bds_pkg::ST_ADVANCE:   cmd.advance = 1'b1;
      bds_pkg::ST_FINISH:    cmd.load_out = sts.out_free;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/baud_divisor_search.sv -----
// ----------------------------------------------------------------------------
// Baud divisor search: prescaler and fractional divider from a baud request
// The target division comes first, then one 30-step serial division per prescaler
// tried for each candidate product in turn. One request at a time: in_stall stays
// high until the result is loaded, and output stalls hold it longer. Reset
// (synchronous, active low) idles the controller and drops out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module baud_divisor_search (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bds_pkg::BAUD_W-1:0]        in_baud,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bds_pkg::PRESCALE_W-1:0]         out_prescale,
  output logic [bds_pkg::DIV_INT_W-1:0]          out_div_int,
  output logic [bds_pkg::FRAC_W-1:0]             out_div_frac,
  output logic [bds_pkg::PRODUCT_W-1:0]          out_achieved_product
);

  bds_pkg::cmd_t    cmd;
  bds_pkg::status_t sts;

  bds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  bds_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_baud              (in_baud),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_prescale         (out_prescale),
    .out_div_int          (out_div_int),
    .out_div_frac         (out_div_frac),
    .out_achieved_product (out_achieved_product)
  );

endmodule

`default_nettype wire
